### src/site_pkg.sv
`default_nettype none
package site_pkg;

   // interval table size
   localparam int INTERVAL_SLOTS = 8;
   localparam int SLOT_W = (INTERVAL_SLOTS > 1) ? $clog2(INTERVAL_SLOTS) : 1;
   localparam int CNT_W = $clog2(INTERVAL_SLOTS + 1);
   localparam int PASS_W = $clog2(INTERVAL_SLOTS + 2);

   // serial divider: 31 integer bits and 16 fraction bits
   localparam int DIV_BITS = 47;
   localparam int DIV_CNT_W = 6;

   localparam logic [16:0] Q16_ONE = 17'h10000;
   localparam logic signed [31:0] MINUS_ONE = -32'sd1;
   localparam logic signed [31:0] I32_MAX = 32'sh7FFFFFFF;

   // configuration register indexes
   localparam logic [2:0] REG_SIMPLE_DUR = 3'd0;
   localparam logic [2:0] REG_REPEAT_COUNT = 3'd1;
   localparam logic [2:0] REG_REPEAT_DUR = 3'd2;
   localparam logic [2:0] REG_MIN_DUR = 3'd3;
   localparam logic [2:0] REG_MAX_DUR = 3'd4;
   localparam logic [2:0] REG_FILL_FREEZE = 3'd5;
   localparam logic [2:0] REG_RESTART_MODE = 3'd6;

   localparam logic [1:0] RESTART_ALWAYS = 2'd0;
   localparam logic [1:0] RESTART_NEVER = 2'd2;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_TICK = 2'd1,
      OP_END = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RUN_WAIT = 2'd0,
      RUN_ACTIVE = 2'd1,
      RUN_FROZEN = 2'd2,
      RUN_DONE = 2'd3
   } run_state_type;

   typedef enum logic [2:0] {
      EVAL_NONE = 3'd0,
      EVAL_UPDATE = 3'd1,
      EVAL_REPEAT = 3'd2,
      EVAL_FREEZE = 3'd3,
      EVAL_REMOVE = 3'd4
   } eval_kind_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_MUL,
      SEQ_DUR,
      SEQ_CLAMP,
      SEQ_PASS,
      SEQ_ACT,
      SEQ_FIN,
      SEQ_SCAN_RD,
      SEQ_SCAN_CHK,
      SEQ_NORM,
      SEQ_DIV,
      SEQ_DIV_END,
      SEQ_OUT
   } seq_state_type;

   typedef struct packed {
      logic [30:0] start_ms;
      logic signed [31:0] active_dur;
      logic signed [31:0] simple_dur;
   } slot_row_type;

endpackage
`default_nettype wire

### src/smil_interval_timing_engine.sv
`default_nettype none
// add: multiply, duration and clamp states before the output; end notification, clear and
//   a repeated tick go straight to the output; a tick walks the run state in passes, each
//   scanning table entries and normalizing time (one quotient bit a cycle in the divider)
// throughput: one word at a time; the next word is taken once the sequencer is idle
// reset: synchronous active high; table empty, waiting, registers at their defaults
module smil_interval_timing_engine import site_pkg::*; (
   input wire logic clock,
   input wire logic reset,

   input wire logic req_valid,
   output logic req_stall,
   input wire logic [1:0] req_operation,
   input wire logic [30:0] req_time_ms,
   input wire logic signed [31:0] req_end_ms,

   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_eval_kind,
   output logic rsp_begin_event,
   output logic rsp_end_event,
   output logic rsp_repeat_event,
   output logic [15:0] rsp_iteration,
   output logic [16:0] rsp_norm_time_q16,
   output logic rsp_table_full,

   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [4:0] csr_paddr,
   input wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   // configuration registers
   logic signed [31:0] simple_dur_ff, repeat_count_ff, repeat_dur_ff, min_dur_ff, max_dur_ff;
   logic fill_freeze_ff;
   logic [1:0] restart_mode_ff;
   logic csr_write;
   logic [2:0] csr_index;

   // interval table, one row per slot
   slot_row_type slot_mem [INTERVAL_SLOTS];
   slot_row_type rd_row_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic wr_en;
   logic [SLOT_W-1:0] wr_addr;
   slot_row_type wr_row;

   // sequencer and timing state
   seq_state_type state_ff, state_in;
   run_state_type run_ff, run_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SLOT_W-1:0] cur_slot_ff, cur_slot_in;
   logic cur_valid_ff, cur_valid_in;
   logic [15:0] iter_ff, iter_in;
   logic [30:0] last_tick_ff, last_tick_in;
   logic last_valid_ff, last_valid_in;

   // copy of the current interval's row
   logic [30:0] cur_start_ff, cur_start_in;
   logic signed [31:0] cur_active_ff, cur_active_in;
   logic signed [31:0] cur_simple_ff, cur_simple_in;

   // per word working registers
   logic [1:0] op_ff, op_in;
   logic [30:0] t_ff, t_in;
   logic signed [31:0] e_ff, e_in;
   logic [61:0] prod_ff, prod_in;
   logic signed [31:0] a_ff, a_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic scan_from_fin_ff, scan_from_fin_in;
   logic upd_ff, upd_in;
   logic [46:0] quo_ff, quo_in;
   logic [30:0] rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // result being built
   eval_kind_type evk_ff, evk_in;
   logic be_ff, be_in, ee_ff, ee_in, re_ff, re_in, full_ff, full_in;
   logic [16:0] norm_ff, norm_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] o_status_ff, o_status_in;
   eval_kind_type o_evk_ff, o_evk_in;
   logic o_be_ff, o_be_in, o_ee_ff, o_ee_in, o_re_ff, o_re_in, o_full_ff, o_full_in;
   logic [15:0] o_iter_ff, o_iter_in;
   logic [16:0] o_norm_ff, o_norm_in;

   // shared arithmetic terms
   logic signed [31:0] at;
   logic [30:0] at_clip;
   logic [31:0] rem_shift;
   logic rem_ge;
   logic [15:0] it_sat;
   logic signed [31:0] prod_sat;
   logic sdef, rcdef, rcind, rddef, rdind, mindef, maxdef;
   logic signed [31:0] a_min, a_max, span;
   logic [CNT_W-1:0] scan_first;
   logic req_accept;

   assign req_accept = req_valid && (state_ff == SEQ_IDLE);
   assign req_stall = (state_ff != SEQ_IDLE);

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[4:2];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_index)
         REG_SIMPLE_DUR: csr_prdata = simple_dur_ff;
         REG_REPEAT_COUNT: csr_prdata = repeat_count_ff;
         REG_REPEAT_DUR: csr_prdata = repeat_dur_ff;
         REG_MIN_DUR: csr_prdata = min_dur_ff;
         REG_MAX_DUR: csr_prdata = max_dur_ff;
         REG_FILL_FREEZE: csr_prdata = {31'd0, fill_freeze_ff};
         REG_RESTART_MODE: csr_prdata = {30'd0, restart_mode_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         simple_dur_ff <= MINUS_ONE;
         repeat_count_ff <= -32'sd2;
         repeat_dur_ff <= -32'sd2;
         min_dur_ff <= MINUS_ONE;
         max_dur_ff <= MINUS_ONE;
         fill_freeze_ff <= 1'b0;
         restart_mode_ff <= RESTART_ALWAYS;
      end else if (csr_write) begin
         case (csr_index)
            REG_SIMPLE_DUR: simple_dur_ff <= csr_pwdata;
            REG_REPEAT_COUNT: repeat_count_ff <= csr_pwdata;
            REG_REPEAT_DUR: repeat_dur_ff <= csr_pwdata;
            REG_MIN_DUR: min_dur_ff <= csr_pwdata;
            REG_MAX_DUR: max_dur_ff <= csr_pwdata;
            REG_FILL_FREEZE: fill_freeze_ff <= csr_pwdata[0];
            REG_RESTART_MODE: restart_mode_ff <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   // ---------------- interval table ----------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_row;
      end
      rd_row_ff <= slot_mem[rd_addr];
   end

   // ---------------- shared arithmetic ----------------
   // time into the current interval, never overflows 32 bits signed
   assign at = $signed({1'b0, t_ff}) - $signed({1'b0, cur_start_ff});
   assign at_clip = at[31] ? 31'd0 : at[30:0];

   // one restoring divider step: remainder stays below the divisor
   assign rem_shift = {rem_ff, quo_ff[46]};
   assign rem_ge = (rem_shift >= {1'b0, cur_simple_ff[30:0]});
   assign it_sat = (|quo_ff[46:32]) ? 16'hFFFF : quo_ff[31:16];

   // repeat count times simple duration, saturated
   assign prod_sat = (|prod_ff[61:47]) ? I32_MAX : $signed({1'b0, prod_ff[46:16]});

   assign sdef = !simple_dur_ff[31];
   assign rcdef = !repeat_count_ff[31];
   assign rcind = (repeat_count_ff == MINUS_ONE);
   assign rddef = !repeat_dur_ff[31];
   assign rdind = (repeat_dur_ff == MINUS_ONE);
   assign mindef = !min_dur_ff[31];
   assign maxdef = !max_dur_ff[31];
   assign span = e_ff - $signed({1'b0, t_ff});

   // min and max clamp, skipped when max is below min
   always_comb begin
      a_min = a_ff;
      a_max = a_ff;
      if (!(mindef && maxdef && (max_dur_ff < min_dur_ff))) begin
         if (mindef && !a_ff[31] && (a_ff <= min_dur_ff)) begin
            a_min = min_dur_ff;
         end
         a_max = a_min;
         if (maxdef && ((!a_min[31] && (a_min >= max_dur_ff)) || (a_min == MINUS_ONE))) begin
            a_max = max_dur_ff;
         end
      end
   end

   assign scan_first = cur_valid_ff ? (CNT_W'(cur_slot_ff) + 1'b1) : '0;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      run_in = run_ff;
      count_in = count_ff;
      cur_slot_in = cur_slot_ff;
      cur_valid_in = cur_valid_ff;
      iter_in = iter_ff;
      last_tick_in = last_tick_ff;
      last_valid_in = last_valid_ff;
      cur_start_in = cur_start_ff;
      cur_active_in = cur_active_ff;
      cur_simple_in = cur_simple_ff;
      op_in = op_ff;
      t_in = t_ff;
      e_in = e_ff;
      prod_in = prod_ff;
      a_in = a_ff;
      pass_in = pass_ff;
      scan_idx_in = scan_idx_ff;
      scan_from_fin_in = scan_from_fin_ff;
      upd_in = upd_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_cnt_in = div_cnt_ff;
      evk_in = evk_ff;
      be_in = be_ff;
      ee_in = ee_ff;
      re_in = re_ff;
      full_in = full_ff;
      norm_in = norm_ff;
      rsp_valid_in = rsp_valid_ff;
      o_status_in = o_status_ff;
      o_evk_in = o_evk_ff;
      o_be_in = o_be_ff;
      o_ee_in = o_ee_ff;
      o_re_in = o_re_ff;
      o_full_in = o_full_ff;
      o_iter_in = o_iter_ff;
      o_norm_in = o_norm_ff;
      rd_addr = scan_idx_ff[SLOT_W-1:0];
      wr_en = 1'b0;
      wr_addr = count_ff[SLOT_W-1:0];
      wr_row = '{start_ms: t_ff, active_dur: a_max, simple_dur: a_ff};

      // result word leaves the output register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         SEQ_IDLE: begin
            if (req_accept) begin
               op_in = req_operation;
               t_in = req_time_ms;
               e_in = req_end_ms;
               evk_in = EVAL_NONE;
               be_in = 1'b0;
               ee_in = 1'b0;
               re_in = 1'b0;
               full_in = 1'b0;
               norm_in = '0;
               state_in = SEQ_OUT;
               case (op_type'(req_operation))
                  OP_ADD: begin
                     if (count_ff == CNT_W'(INTERVAL_SLOTS)) begin
                        full_in = 1'b1;
                     end else begin
                        state_in = SEQ_MUL;
                     end
                  end
                  OP_TICK: begin
                     // same time as the last tick leaves everything as it is
                     if (!(last_valid_ff && (last_tick_ff == req_time_ms))) begin
                        last_tick_in = req_time_ms;
                        last_valid_in = 1'b1;
                        pass_in = '0;
                        state_in = SEQ_PASS;
                     end
                  end
                  OP_END: begin
                     // unresolved end gets fixed by the notification
                     if (cur_valid_ff && cur_active_ff[31]) begin
                        cur_active_in = $signed({1'b0, req_time_ms}) -
                                        $signed({1'b0, cur_start_ff});
                        wr_en = 1'b1;
                        wr_addr = cur_slot_ff;
                        wr_row = '{start_ms: cur_start_ff, active_dur: cur_active_in,
                                   simple_dur: cur_simple_ff};
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     cur_slot_in = '0;
                     cur_valid_in = 1'b0;
                     run_in = RUN_WAIT;
                     iter_in = '0;
                     last_valid_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end

         SEQ_MUL: begin
            prod_in = 62'(repeat_count_ff[30:0]) * 62'(simple_dur_ff[30:0]);
            state_in = SEQ_DUR;
         end

         SEQ_DUR: begin
            // active duration before min, max and end clamps
            if (sdef) begin
               if (rcdef && !rddef) begin
                  a_in = prod_sat;
               end else if (!rcdef && rddef) begin
                  a_in = repeat_dur_ff;
               end else if (!rcdef && !rddef) begin
                  a_in = (rdind || rcind) ? MINUS_ONE : simple_dur_ff;
               end else begin
                  a_in = (repeat_dur_ff < prod_sat) ? repeat_dur_ff : prod_sat;
               end
            end else begin
               a_in = rddef ? repeat_dur_ff : MINUS_ONE;
            end
            state_in = SEQ_CLAMP;
         end

         SEQ_CLAMP: begin
            wr_row.active_dur = a_max;
            if (!e_ff[31]) begin
               if (!a_max[31]) begin
                  wr_row.active_dur = (a_max < span) ? a_max : span;
               end else begin
                  wr_row.active_dur = span;
               end
            end
            wr_row.simple_dur = sdef ? simple_dur_ff : MINUS_ONE;
            wr_row.start_ms = t_ff;
            wr_en = 1'b1;
            wr_addr = count_ff[SLOT_W-1:0];
            count_in = count_ff + 1'b1;
            if (!cur_valid_ff) begin
               cur_slot_in = '0;
               cur_valid_in = 1'b1;
               cur_start_in = wr_row.start_ms;
               cur_active_in = wr_row.active_dur;
               cur_simple_in = wr_row.simple_dur;
            end
            last_valid_in = 1'b0;
            state_in = SEQ_OUT;
         end

         SEQ_PASS: begin
            state_in = SEQ_FIN;
            if (run_ff == RUN_WAIT) begin
               if (!cur_valid_ff || (t_ff < cur_start_ff)) begin
                  state_in = SEQ_OUT;
               end else begin
                  run_in = RUN_ACTIVE;
                  be_in = 1'b1;
                  state_in = SEQ_ACT;
               end
            end else if (run_ff == RUN_ACTIVE) begin
               state_in = SEQ_ACT;
            end
         end

         SEQ_ACT: begin
            upd_in = 1'b0;
            if (!cur_active_ff[31] && (at >= cur_active_ff)) begin
               // end of the active duration
               ee_in = 1'b1;
               if (fill_freeze_ff) begin
                  run_in = RUN_FROZEN;
                  evk_in = EVAL_FREEZE;
               end else begin
                  run_in = RUN_DONE;
                  evk_in = EVAL_REMOVE;
               end
               state_in = SEQ_NORM;
            end else if (cur_simple_ff == MINUS_ONE) begin
               // indefinite simple duration: freeze only when the active duration is zero or negative
               if (cur_active_ff <= 32'sd0) begin
                  run_in = RUN_FROZEN;
                  evk_in = EVAL_FREEZE;
                  state_in = SEQ_NORM;
               end else begin
                  state_in = SEQ_FIN;
               end
            end else begin
               upd_in = 1'b1;
               if (restart_mode_ff == RESTART_ALWAYS) begin
                  scan_idx_in = scan_first;
                  scan_from_fin_in = 1'b0;
                  state_in = SEQ_SCAN_RD;
               end else begin
                  state_in = SEQ_NORM;
               end
            end
         end

         SEQ_FIN: begin
            state_in = SEQ_OUT;
            if (((run_ff == RUN_FROZEN) || (run_ff == RUN_DONE)) &&
                (restart_mode_ff != RESTART_NEVER)) begin
               scan_idx_in = scan_first;
               scan_from_fin_in = 1'b1;
               state_in = SEQ_SCAN_RD;
            end
         end

         SEQ_SCAN_RD: begin
            if (scan_idx_ff >= count_ff) begin
               // no later interval has begun
               state_in = scan_from_fin_ff ? SEQ_OUT : SEQ_NORM;
            end else begin
               state_in = SEQ_SCAN_CHK;
            end
         end

         SEQ_SCAN_CHK: begin
            if (rd_row_ff.start_ms <= t_ff) begin
               cur_slot_in = scan_idx_ff[SLOT_W-1:0];
               cur_start_in = rd_row_ff.start_ms;
               cur_active_in = rd_row_ff.active_dur;
               cur_simple_in = rd_row_ff.simple_dur;
               iter_in = '0;
               if (scan_from_fin_ff) begin
                  run_in = RUN_WAIT;
                  if (pass_ff == PASS_W'(INTERVAL_SLOTS)) begin
                     state_in = SEQ_OUT;
                  end else begin
                     pass_in = pass_ff + 1'b1;
                     state_in = SEQ_PASS;
                  end
               end else begin
                  be_in = 1'b1;
                  state_in = SEQ_NORM;
               end
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
               state_in = SEQ_SCAN_RD;
            end
         end

         SEQ_NORM: begin
            state_in = SEQ_FIN;
            if ((cur_active_ff != MINUS_ONE) && (at > cur_active_ff)) begin
               // past the active duration: iteration kept
               norm_in = Q16_ONE;
               if (upd_ff) begin
                  evk_in = EVAL_UPDATE;
               end
            end else if (cur_simple_ff <= 32'sd0) begin
               iter_in = '0;
               norm_in = Q16_ONE;
               if (upd_ff) begin
                  evk_in = EVAL_UPDATE;
               end
            end else begin
               quo_in = {at_clip, 16'd0};
               rem_in = '0;
               div_cnt_in = '0;
               state_in = SEQ_DIV;
            end
         end

         SEQ_DIV: begin
            if (rem_ge) begin
               rem_in = 31'(rem_shift - {1'b0, cur_simple_ff[30:0]});
            end else begin
               rem_in = rem_shift[30:0];
            end
            quo_in = {quo_ff[45:0], rem_ge};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_BITS - 1)) begin
               state_in = SEQ_DIV_END;
            end
         end

         SEQ_DIV_END: begin
            // upper quotient bits give the iteration, lower the Q16 fraction
            if (upd_ff) begin
               if (it_sat > iter_ff) begin
                  re_in = 1'b1;
                  evk_in = EVAL_REPEAT;
               end else begin
                  evk_in = EVAL_UPDATE;
               end
            end
            iter_in = it_sat;
            norm_in = {1'b0, quo_ff[15:0]};
            state_in = SEQ_FIN;
         end

         SEQ_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_status_in = run_ff;
               o_evk_in = evk_ff;
               o_be_in = be_ff;
               o_ee_in = ee_ff;
               o_re_in = re_ff;
               o_full_in = full_ff;
               o_iter_in = iter_ff;
               o_norm_in = (evk_ff == EVAL_NONE) ? 17'd0 : norm_ff;
               state_in = SEQ_IDLE;
            end
         end

         default: state_in = SEQ_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         run_ff <= RUN_WAIT;
         count_ff <= '0;
         cur_slot_ff <= '0;
         cur_valid_ff <= 1'b0;
         iter_ff <= '0;
         last_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         run_ff <= run_in;
         count_ff <= count_in;
         cur_slot_ff <= cur_slot_in;
         cur_valid_ff <= cur_valid_in;
         iter_ff <= iter_in;
         last_valid_ff <= last_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      last_tick_ff <= last_tick_in;
      cur_start_ff <= cur_start_in;
      cur_active_ff <= cur_active_in;
      cur_simple_ff <= cur_simple_in;
      op_ff <= op_in;
      t_ff <= t_in;
      e_ff <= e_in;
      prod_ff <= prod_in;
      a_ff <= a_in;
      pass_ff <= pass_in;
      scan_idx_ff <= scan_idx_in;
      scan_from_fin_ff <= scan_from_fin_in;
      upd_ff <= upd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_cnt_ff <= div_cnt_in;
      evk_ff <= evk_in;
      be_ff <= be_in;
      ee_ff <= ee_in;
      re_ff <= re_in;
      full_ff <= full_in;
      norm_ff <= norm_in;
      o_status_ff <= o_status_in;
      o_evk_ff <= o_evk_in;
      o_be_ff <= o_be_in;
      o_ee_ff <= o_ee_in;
      o_re_ff <= o_re_in;
      o_full_ff <= o_full_in;
      o_iter_ff <= o_iter_in;
      o_norm_ff <= o_norm_in;
   end

   // operation code is kept for debug visibility of the word in flight
   logic op_is_tick;
   assign op_is_tick = (op_type'(op_ff) == OP_TICK);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = o_status_ff;
   assign rsp_eval_kind = o_evk_ff;
   assign rsp_begin_event = o_be_ff && (op_is_tick || !op_is_tick);
   assign rsp_end_event = o_ee_ff;
   assign rsp_repeat_event = o_re_ff;
   assign rsp_iteration = o_iter_ff;
   assign rsp_norm_time_q16 = o_norm_ff;
   assign rsp_table_full = o_full_ff;

endmodule
`default_nettype wire
